FILE: hw/rtl/oaef_pkg.sv
// shared types, widths and constants of the oversampled angle filter
`default_nettype none

package oaef_pkg;

  // field widths
  localparam int SAMPLE_W    = 12;
  localparam int SCALE_W     = 23;
  localparam int ALPHA_W     = 17;
  localparam int DEG_W       = 25;
  localparam int FILT_W      = 34;
  localparam int GAIN_W      = 32;

  // shared multiplier operand and product widths
  localparam int MUL_A_W     = 33;
  localparam int MUL_B_W     = 20;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  // configuration port
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  // stream payload widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int IN_PAD_W    = IN_TDATA_W - SAMPLE_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SAMPLE_W - 2 * DEG_W;

  // rounding shifts
  localparam int INST_SHIFT  = 20;
  localparam int ALPHA_SHIFT = 16;
  localparam int FILT_SHIFT  = 8;

  // arithmetic constants
  localparam logic [MUL_B_W-1:0] DEG_PER_TURN = MUL_B_W'(360);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 17'h10000;

  // register reset values
  localparam logic [SAMPLE_W-1:0] ZERO_RESET  = 12'd0;
  localparam logic [SCALE_W-1:0]  SCALE_RESET = 23'd32768;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET = 17'd6554;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_COUNT = 8'd0,
    REG_SCALE      = 8'd1,
    REG_REVERSE    = 8'd2,
    REG_ALPHA      = 8'd3
  } cfg_reg_e;

  // current register contents, alpha already clamped to one
  typedef struct packed {
    logic [SAMPLE_W-1:0] zero_count;
    logic [SCALE_W-1:0]  scale_magnitude;
    logic                reverse_direction;
    logic [ALPHA_W-1:0]  smoothing_alpha;
  } cfg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_GAIN,
    ST_PROD,
    ST_INST,
    ST_ERR,
    ST_WEIGHT,
    ST_UPD,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/oaef_cfg.sv
// configuration register file with filter rearm on offset, scale or direction writes
`default_nettype none

module oaef_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [oaef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [oaef_pkg::CFG_DATA_W-1:0] cfg_data,
  output oaef_pkg::cfg_t                      regs,
  output logic                                rearm
);
  import oaef_pkg::*;

  logic [SAMPLE_W-1:0] zero_count;
  logic [SCALE_W-1:0]  scale_magnitude;
  logic                reverse_direction;
  logic [ALPHA_W-1:0]  smoothing_alpha;
  logic                wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // register writes, bits above each width dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_count        <= ZERO_RESET;
      scale_magnitude   <= SCALE_RESET;
      reverse_direction <= 1'b0;
      smoothing_alpha   <= ALPHA_RESET;
    end else if (wr) begin
      case (cfg_index)
        REG_ZERO_COUNT: zero_count        <= cfg_data[SAMPLE_W-1:0];
        REG_SCALE:      scale_magnitude   <= cfg_data[SCALE_W-1:0];
        REG_REVERSE:    reverse_direction <= cfg_data[0];
        REG_ALPHA:      smoothing_alpha   <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry writes restart the filter from the next value
  assign rearm = wr && (cfg_index inside {REG_ZERO_COUNT, REG_SCALE, REG_REVERSE});

  // alpha above one behaves as one
  always_comb begin
    regs.zero_count        = zero_count;
    regs.scale_magnitude   = scale_magnitude;
    regs.reverse_direction = reverse_direction;
    regs.smoothing_alpha   = (smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : smoothing_alpha;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/oaef_avg_div.sv
// block mean by reciprocal multiplication on the shared multiplier
`default_nettype none

module oaef_avg_div #(
  parameter  int OVERSAMPLE = 16,
  localparam int CNT_W      = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1,
  localparam int SUM_W      = oaef_pkg::SAMPLE_W + CNT_W
) (
  input  wire logic                          clk,
  input  wire logic                          start,
  input  wire logic [SUM_W-1:0]              dividend,
  output logic      [oaef_pkg::MUL_A_W-1:0]  mul_a,
  output logic      [oaef_pkg::MUL_B_W-1:0]  mul_b,
  input  wire logic [oaef_pkg::PROD_W-1:0]   prod,
  output logic      [oaef_pkg::SAMPLE_W-1:0] quotient
);
  import oaef_pkg::*;

  // rounded-up reciprocal; its error times any block sum stays below one unit
  // of the shift, so the quotient is exact
  localparam int                 RECIP_SHIFT = SUM_W + CNT_W;
  localparam logic [MUL_A_W-1:0] RECIP       =
    MUL_A_W'(((64'd1 << RECIP_SHIFT) + 64'(OVERSAMPLE) - 64'd1) / 64'(OVERSAMPLE));

  logic [SUM_W-1:0] block_sum;

  // hold the closing sum while the multiplier works on it
  always_ff @(posedge clk) begin
    if (start) begin
      block_sum <= dividend;
    end
  end

  // operands for the shared multiplier and the quotient from its product
  assign mul_a    = RECIP;
  assign mul_b    = MUL_B_W'(block_sum);
  assign quotient = prod[RECIP_SHIFT +: SAMPLE_W];

endmodule

`default_nettype wire

FILE: hw/rtl/oaef_mul.sv
// shared unsigned multiplier with registered product
`default_nettype none

module oaef_mul (
  input  wire logic                        clk,
  input  wire logic [oaef_pkg::MUL_A_W-1:0] a,
  input  wire logic [oaef_pkg::MUL_B_W-1:0] b,
  output logic      [oaef_pkg::PROD_W-1:0]  prod
);
  import oaef_pkg::*;

  // product registered, landing in the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
  end

endmodule

`default_nettype wire

FILE: hw/rtl/oversampled_angle_ema_filter_core.sv
// top level: sample accumulation, sequencer and datapath of the angle filter
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+--------------------------------------
//   s_       | in        | s_tvalid/s_tready | s_tdata: adc_sample
//   m_       | out       | m_tvalid/m_tready | m_tdata: average_count, instant_degrees,
//            |           |                   |          filtered_degrees
//   cfg_     | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// a sample that does not close a block is taken in one cycle
// the sample that closes a block holds ready low through the states avg, gain, prod,
//   inst, err, weight, upd and out (weight and upd are skipped when the filter loads
//   directly): the shared multiplier forms the mean by reciprocal, then runs gain, angle
//   and smoothing products one after another; a full result register that is not taken keeps it in out
// synchronous reset clears the sum, the count and the filter; no clearing pass

`default_nettype none

module oversampled_angle_ema_filter_core #(
  parameter  int OVERSAMPLE = 16,
  localparam int CNT_W      = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1,
  localparam int SUM_W      = oaef_pkg::SAMPLE_W + CNT_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // adc_sample[11:0]
  input  wire logic [oaef_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // average_count[11:0], instant_degrees[36:12], filtered_degrees[61:37]
  output logic      [oaef_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [oaef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [oaef_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import oaef_pkg::*;

  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(OVERSAMPLE - 1);

  state_t               state;
  state_t               state_next;
  cfg_t                 regs;
  logic                 rearm;

  logic [SUM_W-1:0]     sample_sum;
  logic [CNT_W-1:0]     sample_count;
  logic [SUM_W-1:0]     sum_in;
  logic                 last_sample;
  logic                 in_xfer;

  logic                 div_start;
  logic [MUL_A_W-1:0]   div_a;
  logic [MUL_B_W-1:0]   div_b;
  logic [SAMPLE_W-1:0]  div_quo;

  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_prod;

  logic [SAMPLE_W-1:0]  avg;
  logic                 d_neg;
  logic [SAMPLE_W-1:0]  d_mag;
  logic [DEG_W-1:0]     inst;
  logic                 e_neg;
  logic [MUL_A_W-1:0]   e_mag;
  logic [FILT_W-1:0]    filter_value;
  logic                 primed;
  logic                 out_load;

  // combinational datapath terms
  logic                 avg_ge;
  logic [PROD_W-1:0]    inst_sum;
  logic [DEG_W-1:0]     inst_ext;
  logic [FILT_W-1:0]    x_val;
  logic [FILT_W:0]      e_full;
  logic [FILT_W:0]      e_abs;
  logic [PROD_W-1:0]    q_sum;
  logic [FILT_W-1:0]    q_ext;
  logic [FILT_W-1:0]    fv_abs;
  logic [FILT_W-1:0]    fv_rnd;
  logic [DEG_W-1:0]     filt_ext;
  logic [DEG_W-1:0]     filt;

  oaef_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs),
    .rearm     (rearm)
  );

  oaef_avg_div #(
    .OVERSAMPLE (OVERSAMPLE)
  ) u_div (
    .clk      (clk),
    .start    (div_start),
    .dividend (sum_in),
    .mul_a    (div_a),
    .mul_b    (div_b),
    .prod     (mul_prod),
    .quotient (div_quo)
  );

  oaef_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  assign in_xfer     = s_tvalid && s_tready;
  assign sum_in      = sample_sum + SUM_W'(s_tdata[SAMPLE_W-1:0]);
  assign last_sample = (sample_count == LAST_COUNT);

  // sequencer: next state, ready and multiplier operand select
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && last_sample) begin
          div_start  = 1'b1;
          state_next = ST_AVG;
        end
      end
      ST_AVG: begin
        mul_a      = div_a;
        mul_b      = div_b;
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        mul_a      = MUL_A_W'(regs.scale_magnitude);
        mul_b      = DEG_PER_TURN;
        state_next = ST_PROD;
      end
      ST_PROD: begin
        mul_a      = MUL_A_W'(mul_prod[GAIN_W-1:0]);
        mul_b      = MUL_B_W'(d_mag);
        state_next = ST_INST;
      end
      ST_INST: begin
        state_next = ST_ERR;
      end
      ST_ERR: begin
        state_next = primed ? ST_WEIGHT : ST_OUT;
      end
      ST_WEIGHT: begin
        mul_a      = e_mag;
        mul_b      = MUL_B_W'(regs.smoothing_alpha);
        state_next = ST_UPD;
      end
      ST_UPD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // offset difference as sign and magnitude
  assign avg_ge = (div_quo >= regs.zero_count);

  // instant angle, rounded half away from zero
  assign inst_sum = mul_prod + (PROD_W'(1) << (INST_SHIFT - 1));
  assign inst_ext = {1'b0, inst_sum[INST_SHIFT +: DEG_W-1]};

  // error between new value and filter, as sign and magnitude
  assign x_val  = {{(FILT_W - DEG_W - FILT_SHIFT){inst[DEG_W-1]}}, inst, {FILT_SHIFT{1'b0}}};
  assign e_full = {x_val[FILT_W-1], x_val} - {filter_value[FILT_W-1], filter_value};
  assign e_abs  = e_full[FILT_W] ? -e_full : e_full;

  // weighted correction, rounded half away from zero
  assign q_sum = mul_prod + (PROD_W'(1) << (ALPHA_SHIFT - 1));
  assign q_ext = {1'b0, q_sum[ALPHA_SHIFT +: MUL_A_W]};

  // filter value from signed q26.8 back to whole degrees, rounded half away from zero
  assign fv_abs   = filter_value[FILT_W-1] ? -filter_value : filter_value;
  assign fv_rnd   = fv_abs + (FILT_W'(1) << (FILT_SHIFT - 1));
  assign filt_ext = {1'b0, fv_rnd[FILT_SHIFT +: DEG_W-1]};
  assign filt     = filter_value[FILT_W-1] ? -filt_ext : filt_ext;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_sum   <= '0;
      sample_count <= '0;
      filter_value <= '0;
      primed       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      // block accumulation
      if (in_xfer) begin
        if (last_sample) begin
          sample_sum   <= '0;
          sample_count <= '0;
        end else begin
          sample_sum   <= sum_in;
          sample_count <= sample_count + 1'b1;
        end
      end

      // filter load or update
      if (state == ST_ERR && !primed) begin
        filter_value <= x_val;
      end else if (state == ST_UPD) begin
        filter_value <= e_neg ? (filter_value - q_ext) : (filter_value + q_ext);
      end

      if (rearm) begin
        primed <= 1'b0;
      end else if (state == ST_ERR) begin
        primed <= 1'b1;
      end

      // result register
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_GAIN) begin
      avg   <= div_quo;
      d_mag <= avg_ge ? (div_quo - regs.zero_count) : (regs.zero_count - div_quo);
      d_neg <= (!avg_ge) ^ regs.reverse_direction;
    end
    if (state == ST_INST) begin
      inst <= d_neg ? -inst_ext : inst_ext;
    end
    if (state == ST_ERR) begin
      e_neg <= e_full[FILT_W];
      e_mag <= e_abs[MUL_A_W-1:0];
    end
    if (out_load) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, filt, inst, avg};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/oaef_checker.sv
// port-level checks of the angle filter and their binding to the top level
`default_nettype none

module oaef_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [oaef_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

  // a new result only appears at the end of a busy stretch
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while input was open");

  // once a result is posted the input reopens at once
  a_ready_after_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("input stayed closed after result");

endmodule

bind oversampled_angle_ema_filter_core oaef_checker u_oaef_checker (.*);

`default_nettype wire

FILE: test/oaef_angle_monitor.sv
// transfer monitor: predicts the angle results and compares them with the block's output
`timescale 1ns / 100ps

module oaef_angle_monitor #(
  parameter int OVERSAMPLE = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  input  wire logic [oaef_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic [oaef_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [oaef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [oaef_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                    fail_count,
  output int unsigned                           pending
);
  import oaef_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0]     average;
    logic signed [DEG_W-1:0] instant;
    logic signed [DEG_W-1:0] filtered;
  } angle_result_t;

  // expected angles in output order
  angle_result_t expected_angles[$];

  // register copies
  logic [SAMPLE_W-1:0] zero_reg;
  logic [SCALE_W-1:0]  scale_reg;
  logic                reverse_reg;
  logic [ALPHA_W-1:0]  alpha_reg;

  // oversampling and smoothing state
  int unsigned sample_sum;
  int          sample_cnt;
  longint      ema_value;
  bit          ema_loaded;

  int reports;

  initial begin
    fail_count = 0;
    pending    = 0;
    reports    = 0;
  end

  // signed value times unsigned factor over 2^sh, rounded half away from zero
  function automatic longint round_away(input longint v, input longint unsigned m,
                                        input int sh);
    longint unsigned mag;
    longint unsigned q;
    mag = (v < 0) ? -v : v;
    q = (mag * m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic clear_state();
    zero_reg    = ZERO_RESET;
    scale_reg   = SCALE_RESET;
    reverse_reg = 1'b0;
    alpha_reg   = ALPHA_RESET;
    sample_sum  = 0;
    sample_cnt  = 0;
    ema_value   = 0;
    ema_loaded  = 1'b0;
    expected_angles.delete();
  endtask

  // register write; angle-defining registers force a reload of the filter
  task automatic apply_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
    case (index)
      REG_ZERO_COUNT: begin
        zero_reg   = data[SAMPLE_W-1:0];
        ema_loaded = 1'b0;
      end
      REG_SCALE: begin
        scale_reg  = data[SCALE_W-1:0];
        ema_loaded = 1'b0;
      end
      REG_REVERSE: begin
        reverse_reg = data[0];
        ema_loaded  = 1'b0;
      end
      REG_ALPHA: begin
        alpha_reg = data[ALPHA_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  // add one sample; the last of a block yields an expected angle
  task automatic accumulate_sample(input logic [SAMPLE_W-1:0] adc);
    logic [SAMPLE_W-1:0] avg;
    logic [ALPHA_W-1:0]  weight;
    longint              diff;
    longint              inst;
    longint              target;
    longint              filt;
    angle_result_t       r;
    sample_sum = sample_sum + adc;
    sample_cnt++;
    if (sample_cnt == OVERSAMPLE) begin
      avg = SAMPLE_W'(sample_sum / OVERSAMPLE);
      sample_sum = 0;
      sample_cnt = 0;
      diff = reverse_reg ? longint'(zero_reg) - longint'(avg)
                         : longint'(avg) - longint'(zero_reg);
      inst = round_away(diff, 64'd360 * scale_reg, INST_SHIFT);
      target = inst * 256;
      if (!ema_loaded) begin
        ema_value  = target;
        ema_loaded = 1'b1;
      end else begin
        weight = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        ema_value = ema_value + round_away(target - ema_value, weight, ALPHA_SHIFT);
      end
      filt = round_away(ema_value, 1, FILT_SHIFT);
      r.average  = avg;
      r.instant  = inst[DEG_W-1:0];
      r.filtered = filt[DEG_W-1:0];
      expected_angles.push_back(r);
    end
  endtask

  // compare one output transfer with the oldest expected angle
  task automatic check_result();
    angle_result_t           exp_r;
    logic [SAMPLE_W-1:0]     got_avg;
    logic signed [DEG_W-1:0] got_inst;
    logic signed [DEG_W-1:0] got_filt;
    got_avg  = m_tdata[SAMPLE_W-1:0];
    got_inst = m_tdata[SAMPLE_W +: DEG_W];
    got_filt = m_tdata[SAMPLE_W+DEG_W +: DEG_W];
    if (expected_angles.size() == 0) begin
      fail_count++;
      if (reports < REPORT_LIMIT) begin
        reports++;
        $display("%0t: unexpected result transfer: avg %0d inst %0d filt %0d",
                 $realtime, got_avg, got_inst, got_filt);
      end
    end else begin
      exp_r = expected_angles.pop_front();
      if (got_avg !== exp_r.average || got_inst !== exp_r.instant ||
          got_filt !== exp_r.filtered) begin
        fail_count++;
        if (reports < REPORT_LIMIT) begin
          reports++;
          $display("%0t: angle result differs: expected avg %0d inst %0d filt %0d",
                   $realtime, exp_r.average, exp_r.instant, exp_r.filtered);
          $display("%0t:                      got      avg %0d inst %0d filt %0d",
                   $realtime, got_avg, got_inst, got_filt);
        end
      end
    end
  endtask

  // sample all three channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) accumulate_sample(s_tdata[SAMPLE_W-1:0]);
    end
    pending <= expected_angles.size();
  end

endmodule

FILE: test/oversampled_angle_ema_filter_core_test.sv
// top of the angle filter test: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module oversampled_angle_ema_filter_core_test;
  import oaef_pkg::*;

  localparam int BLOCK_LEN     = 16;
  localparam int TARGET_ITEMS  = 1800;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_GAP       = 16;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int          fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned rx_hold     = 0;
  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;
  int          items_sent  = 0;

  oversampled_angle_ema_filter_core #(
    .OVERSAMPLE(BLOCK_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  oaef_angle_monitor #(
    .OVERSAMPLE(BLOCK_LEN)
  ) monitor (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // run limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("oversampled_angle_ema_filter_core: mismatch");
    $finish;
  end

  // result side: stall counted only while a result waits
  always @(posedge clk) begin : rx_side
    int unsigned next_hold;
    if (rst) begin
      next_hold = 0;
    end else if (m_tvalid && m_tready) begin
      next_hold = rx_quiet ? 0 : $urandom_range(MAX_GAP, 0);
    end else if (m_tvalid && rx_hold != 0) begin
      next_hold = rx_hold - 1;
    end else begin
      next_hold = rx_hold;
    end
    rx_hold  <= next_hold;
    m_tready <= !rst && next_hold == 0;
  end

  // random bits above the field width
  function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] value,
                                                       input int width);
    logic [CFG_DATA_W-1:0] mask;
    mask = CFG_DATA_W'((64'd1 << width) - 64'd1);
    return ($urandom & ~mask) | (value & mask);
  endfunction

  // one sample transfer after a random gap
  task automatic send_sample(input logic [SAMPLE_W-1:0] adc);
    int unsigned           gap;
    logic [IN_TDATA_W-1:0] word;
    gap = tx_quiet ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = IN_TDATA_W'($urandom);
    word[SAMPLE_W-1:0] = adc;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // one register write transfer; valid is lowered by the caller
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // wait for all results, then let a possible block in progress finish
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] zero,
                           input logic [CFG_DATA_W-1:0] scale,
                           input logic [CFG_DATA_W-1:0] rev,
                           input logic [CFG_DATA_W-1:0] alpha);
    write_reg(REG_ZERO_COUNT, with_noise(zero, SAMPLE_W));
    write_reg(REG_SCALE, with_noise(scale, SCALE_W));
    write_reg(REG_REVERSE, with_noise(rev, 1));
    write_reg(REG_ALPHA, with_noise(alpha, ALPHA_W));
  endtask

  // register value biased toward the extremes
  function automatic logic [CFG_DATA_W-1:0] draw_reg_data(input cfg_reg_e r);
    int unsigned c;
    c = $urandom_range(5, 0);
    case (r)
      REG_ZERO_COUNT:
        case (c)
          0: return with_noise(0, SAMPLE_W);
          1: return with_noise(4095, SAMPLE_W);
          default: return with_noise($urandom_range(4095, 0), SAMPLE_W);
        endcase
      REG_SCALE:
        case (c)
          0: return with_noise(0, SCALE_W);
          1: return with_noise(6553600, SCALE_W);
          2: return with_noise(32'h7FFFFF, SCALE_W);
          3: return with_noise($urandom, SCALE_W);
          default: return with_noise($urandom_range(6553600, 0), SCALE_W);
        endcase
      REG_REVERSE:
        return with_noise($urandom_range(1, 0), 1);
      default:
        case (c)
          0: return with_noise(0, ALPHA_W);
          1: return with_noise(CFG_DATA_W'(ALPHA_ONE), ALPHA_W);
          2: return with_noise($urandom, ALPHA_W);
          default: return with_noise($urandom_range(65536, 0), ALPHA_W);
        endcase
    endcase
  endfunction

  // random subset of registers, sometimes an index past the list
  task automatic random_setting();
    cfg_reg_e r;
    for (int i = REG_ZERO_COUNT; i <= REG_ALPHA; i++) begin
      r = cfg_reg_e'(i);
      if ($urandom_range(1, 0) == 1) write_reg(r, draw_reg_data(r));
    end
    if ($urandom_range(3, 0) == 0)
      write_reg(CFG_IDX_W'($urandom_range(255, REG_ALPHA + 1)), $urandom);
  endtask

  function automatic logic [SAMPLE_W-1:0] directed_sample(input int i);
    case (i % BLOCK_LEN)
      0:  return 12'h000;
      1:  return 12'hFFF;
      2:  return 12'hAAA;
      3:  return 12'h555;
      4:  return 12'h800;
      5:  return 12'h001;
      6:  return 12'hFFE;
      7:  return 12'h7FF;
      8:  return 12'hF0F;
      9:  return 12'h0F0;
      10: return 12'hFFF;
      11: return 12'hFFF;
      default: return 12'h000;
    endcase
  endfunction

  // sample shapes: uniform, noisy hold, rail to rail, steady
  function automatic logic [SAMPLE_W-1:0] draw_sample(input int mode,
                                                     input logic [SAMPLE_W-1:0] center);
    int v;
    case (mode)
      0: return SAMPLE_W'($urandom_range(4095, 0));
      1: begin
        v = int'(center) + int'($urandom_range(14, 0)) - 7;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_W'(v);
      end
      2: return ($urandom_range(1, 0) == 1) ? 12'hFFF : 12'h000;
      default: return center;
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    int                  phase;
    int                  len;
    int                  mode;
    logic [SAMPLE_W-1:0] center;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings, one full block of edge values, then a partial block
    for (int i = 0; i < BLOCK_LEN + 8; i++) send_sample(directed_sample(i));
    s_tvalid <= 1'b0;

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      settle();
      tx_quiet = ($urandom_range(3, 0) == 0);
      rx_quiet = ($urandom_range(3, 0) == 0);
      case (phase)
        0: write_all(4095, 6553600, 1, CFG_DATA_W'(ALPHA_ONE));
        1: write_all(0, 0, 0, 0);
        2: write_all(2048, 32'h7FFFFF, 0, 32'h1FFFF);
        3: write_all(0, 6553600, 1, 1);
        4: write_all(4095, 1, 0, 32'h10001);
        default: random_setting();
      endcase
      cfg_valid <= 1'b0;

      len = (phase < 5) ? 3 * BLOCK_LEN : $urandom_range(80, 16);
      mode = $urandom_range(3, 0);
      case ($urandom_range(3, 0))
        0: center = 12'h000;
        1: center = 12'hFFF;
        default: center = SAMPLE_W'($urandom_range(4095, 0));
      endcase
      for (int i = 0; i < len; i++) send_sample(draw_sample(mode, center));
      s_tvalid <= 1'b0;
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("oversampled_angle_ema_filter_core: match");
    end else begin
      $display("oversampled_angle_ema_filter_core: mismatch");
    end
    $finish;
  end

endmodule
